@@ sv/dmvs_pkg.sv @@
// Shared types and constants for the measuring value scaler.
// No dependencies.
`default_nettype none
package dmvs_pkg;

    localparam int NW   = 32;
    localparam int NUMW = 29;
    localparam int DENW = 18;
    localparam int OUTW = 36;

    localparam logic [7:0] FT_01 = 8'd1;
    localparam logic [7:0] FT_02 = 8'd2;
    localparam logic [7:0] FT_03 = 8'd3;
    localparam logic [7:0] FT_04 = 8'd4;
    localparam logic [7:0] FT_05 = 8'd5;
    localparam logic [7:0] FT_06 = 8'd6;
    localparam logic [7:0] FT_07 = 8'd7;
    localparam logic [7:0] FT_08 = 8'd8;
    localparam logic [7:0] FT_09 = 8'd9;
    localparam logic [7:0] FT_11 = 8'd11;
    localparam logic [7:0] FT_12 = 8'd12;
    localparam logic [7:0] FT_13 = 8'd13;
    localparam logic [7:0] FT_14 = 8'd14;
    localparam logic [7:0] FT_15 = 8'd15;
    localparam logic [7:0] FT_18 = 8'd18;
    localparam logic [7:0] FT_19 = 8'd19;
    localparam logic [7:0] FT_20 = 8'd20;
    localparam logic [7:0] FT_21 = 8'd21;
    localparam logic [7:0] FT_22 = 8'd22;
    localparam logic [7:0] FT_23 = 8'd23;
    localparam logic [7:0] FT_24 = 8'd24;
    localparam logic [7:0] FT_25 = 8'd25;
    localparam logic [7:0] FT_26 = 8'd26;
    localparam logic [7:0] FT_27 = 8'd27;
    localparam logic [7:0] FT_28 = 8'd28;
    localparam logic [7:0] FT_30 = 8'd30;
    localparam logic [7:0] FT_31 = 8'd31;
    localparam logic [7:0] FT_33 = 8'd33;
    localparam logic [7:0] FT_34 = 8'd34;
    localparam logic [7:0] FT_35 = 8'd35;
    localparam logic [7:0] FT_38 = 8'd38;
    localparam logic [7:0] FT_39 = 8'd39;
    localparam logic [7:0] FT_43 = 8'd43;
    localparam logic [7:0] FT_45 = 8'd45;
    localparam logic [7:0] FT_46 = 8'd46;
    localparam logic [7:0] FT_47 = 8'd47;
    localparam logic [7:0] FT_48 = 8'd48;
    localparam logic [7:0] FT_49 = 8'd49;
    localparam logic [7:0] FT_50 = 8'd50;
    localparam logic [7:0] FT_51 = 8'd51;
    localparam logic [7:0] FT_52 = 8'd52;
    localparam logic [7:0] FT_53 = 8'd53;
    localparam logic [7:0] FT_54 = 8'd54;
    localparam logic [7:0] FT_55 = 8'd55;
    localparam logic [7:0] FT_56 = 8'd56;
    localparam logic [7:0] FT_59 = 8'd59;
    localparam logic [7:0] FT_60 = 8'd60;
    localparam logic [7:0] FT_61 = 8'd61;
    localparam logic [7:0] FT_62 = 8'd62;
    localparam logic [7:0] FT_64 = 8'd64;
    localparam logic [7:0] FT_65 = 8'd65;
    localparam logic [7:0] FT_66 = 8'd66;
    localparam logic [7:0] FT_67 = 8'd67;
    localparam logic [7:0] FT_68 = 8'd68;
    localparam logic [7:0] FT_69 = 8'd69;
    localparam logic [7:0] FT_70 = 8'd70;

    typedef struct packed {
        logic [7:0] formula_type;
        logic [7:0] value_a;
        logic [7:0] value_b;
    } t_in;

    typedef struct packed {
        logic signed [OUTW-1:0] scaled_value;
        logic                   type_known;
    } t_out;

    typedef struct packed {
        logic signed [NUMW-1:0] num;
        logic [DENW-1:0]        den;
        logic                   known;
        logic                   trunc;
    } t_item;

endpackage
`default_nettype wire

@@ sv/dmvs_front.sv @@
// Front end: decodes the formula type into a numerator/denominator pair.
// Depends on dmvs_pkg.
`default_nettype none
module dmvs_front (
    input  var dmvs_pkg::t_in   i_item,
    output var dmvs_pkg::t_item o_item
);
    import dmvs_pkg::*;

    logic signed [NW-1:0] a, b, ab, w, num;
    logic [DENW-1:0]      den;
    logic                 known, trunc;

    always_comb begin
        a     = signed'(NW'(i_item.value_a));
        b     = signed'(NW'(i_item.value_b));
        ab    = a * b;
        w     = 256 * a + b;
        num   = '0;
        den   = DENW'(1);
        known = 1'b1;
        trunc = 1'b0;
        unique case (i_item.formula_type)
            FT_01: begin num = ab; den = DENW'(5); end
            FT_02, FT_03: begin num = ab; den = DENW'(500); end
            FT_04: begin
                num = ((b >= 127) ? b - 127 : 127 - b) * a;
                den = DENW'(100);
            end
            FT_05: begin num = a * (b - 100); den = DENW'(10); end
            FT_06, FT_12, FT_21, FT_22, FT_24, FT_45: begin
                num = ab; den = DENW'(1000);
            end
            FT_07, FT_15, FT_19, FT_35: begin num = ab; den = DENW'(100); end
            FT_08: begin num = ab; den = DENW'(10); end
            FT_09: begin num = (b - 127) * a; den = DENW'(50); end
            FT_11: begin num = a * (b - 128) + 10000; den = DENW'(10000); end
            FT_13: begin num = (b - 127) * a; den = DENW'(1000); end
            FT_14, FT_55: begin num = ab; den = DENW'(200); end
            FT_18: begin num = ab; den = DENW'(25); end
            FT_20: begin num = a * (b - 128); den = DENW'(128); end
            FT_23, FT_39: begin num = ab; den = DENW'(256); end
            FT_25: begin num = 1000 * a + 258622 * b; den = DENW'(182000); end
            FT_26, FT_28: num = b - a;
            FT_27: begin
                num = ((b >= 128) ? b - 128 : 128 - b) * a;
                den = DENW'(100);
            end
            FT_30: begin num = ab; den = DENW'(12); end
            FT_31: begin num = ab; den = DENW'(2560); end
            FT_33: begin
                num   = 100 * b;
                den   = (i_item.value_a == 8'd0) ? DENW'(1) : DENW'(i_item.value_a);
                trunc = 1'b1;
            end
            FT_34: begin num = (b - 128) * a; den = DENW'(100); end
            FT_38: begin num = (b - 128) * a; den = DENW'(1000); end
            FT_43: begin num = b + 255 * a; den = DENW'(10); end
            FT_46: begin num = (ab - 3200) * 27; den = DENW'(10000); end
            FT_47: num = (b - 128) * a;
            FT_49: begin num = ab; den = DENW'(40); end
            FT_50: begin
                num = (b - 128) * 100;
                den = (i_item.value_a == 8'd0) ? DENW'(1) : DENW'(i_item.value_a);
            end
            FT_51: begin num = (b - 128) * a; den = DENW'(255); end
            FT_52: begin num = ab - 50 * a; den = DENW'(50); end
            FT_53: begin num = (b - 128) * 14222 + 60 * a; den = DENW'(10000); end
            FT_48, FT_54, FT_56: num = w;
            FT_59: begin num = w; den = DENW'(32768); end
            FT_60: begin num = w; den = DENW'(100); end
            FT_61: begin
                num = b - 128;
                den = (i_item.value_a == 8'd0) ? DENW'(1) : DENW'(i_item.value_a);
            end
            FT_62: begin num = 256 * ab; den = DENW'(1000); end
            FT_64: num = a + b;
            FT_65: begin num = a * (b - 127); den = DENW'(100); end
            FT_66: begin num = ab * 100; den = DENW'(51112); end
            FT_67: begin num = 1280 * a + 5 * b; den = DENW'(2); end
            FT_68: begin num = w * 1000; den = DENW'(7365); end
            FT_69: begin num = w * 3254; den = DENW'(10000); end
            FT_70: begin num = w * 192; den = DENW'(1000); end
            default: known = 1'b0;
        endcase
        o_item.num   = num[NUMW-1:0];
        o_item.den   = den;
        o_item.known = known;
        o_item.trunc = trunc;
    end

endmodule
`default_nettype wire

@@ sv/dmvs_fifo.sv @@
// Four-entry queue between the decode front end and the divider back end.
// Depends on dmvs_pkg.
`default_nettype none
module dmvs_fifo (
    input  var logic            i_clk,
    input  var logic            i_rst_n,
    input  var logic            i_wr,
    input  var dmvs_pkg::t_item i_data,
    input  var logic            i_rd,
    output var dmvs_pkg::t_item o_data,
    output var logic            o_full,
    output var logic            o_empty
);
    import dmvs_pkg::*;

    t_item      r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr, rd;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign wr      = i_wr && !o_full;
    assign rd      = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 2'd1;
            end
            if (rd) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'b0, wr} - {2'b0, rd};
        end
    end

endmodule
`default_nettype wire

@@ sv/dmvs_back.sv @@
// Back end: pipelined restoring divider, rounding, saturation, result register.
// Depends on dmvs_pkg.
`default_nettype none
module dmvs_back #(
    parameter int FRACTION_BITS = 16
) (
    input  var logic            i_clk,
    input  var logic            i_rst_n,
    input  var dmvs_pkg::t_item i_item,
    input  var logic            i_vld,
    output var logic            o_take,
    output var dmvs_pkg::t_out  o_result,
    output var logic            o_empty,
    input  var logic            i_pop
);
    import dmvs_pkg::*;

    localparam int MAGW = NUMW - 1;
    localparam int DW   = MAGW + FRACTION_BITS + 2;
    localparam int RW   = DENW + 1;

    logic [RW-1:0] r_rem [DW+1];
    logic [DW-1:0] r_quo [DW+1];
    logic [RW-1:0] r_div [DW+1];
    logic          r_neg [DW+1];
    logic          r_known [DW+1];
    logic          r_trunc [DW+1];
    logic          r_vld [DW+1];
    t_out          r_out;
    logic          r_out_vld;

    logic            en;
    logic [MAGW-1:0] mag;
    logic [DW-1:0]   dvd;
    logic [DW-1:0]   q;
    logic            hi, pos_over, neg_over;
    logic signed [OUTW-1:0] val;

    assign en       = !r_out_vld || i_pop;
    assign o_take   = en && i_vld;
    assign o_empty  = !r_out_vld;
    assign o_result = r_out;

    always_comb begin
        mag = i_item.num[NUMW-1] ? MAGW'(-i_item.num) : MAGW'(i_item.num);
        dvd = {1'b0, mag, {(FRACTION_BITS + 1){1'b0}}}
            + (i_item.trunc ? DW'(0) : DW'(i_item.den));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0]   <= '0;
            r_quo[0]   <= dvd;
            r_div[0]   <= {i_item.den, 1'b0};
            r_neg[0]   <= i_item.num[NUMW-1];
            r_known[0] <= i_item.known;
            r_trunc[0] <= i_item.trunc;
        end
    end

    for (genvar k = 1; k <= DW; k++) begin : g_div
        logic [RW:0] t;
        logic        ge;
        assign t  = {r_rem[k-1], r_quo[k-1][DW-1]};
        assign ge = (t >= {1'b0, r_div[k-1]});
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[k]   <= ge ? RW'(t - {1'b0, r_div[k-1]}) : t[RW-1:0];
                r_quo[k]   <= {r_quo[k-1][DW-2:0], ge};
                r_div[k]   <= r_div[k-1];
                r_neg[k]   <= r_neg[k-1];
                r_known[k] <= r_known[k-1];
                r_trunc[k] <= r_trunc[k-1];
            end
        end
    end

    always_comb begin
        q        = r_trunc[DW] ? {r_quo[DW][DW-1:FRACTION_BITS], {FRACTION_BITS{1'b0}}}
                               : r_quo[DW];
        hi       = |q[DW-1:OUTW];
        pos_over = hi || q[OUTW-1];
        neg_over = hi || (q[OUTW-1] && (|q[OUTW-2:0]));
        if (!r_known[DW]) begin
            val = '0;
        end else if (r_neg[DW]) begin
            val = neg_over ? {1'b1, {(OUTW - 1){1'b0}}} : -signed'(q[OUTW-1:0]);
        end else begin
            val = pos_over ? {1'b0, {(OUTW - 1){1'b1}}} : signed'(q[OUTW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.scaled_value <= val;
            r_out.type_known   <= r_known[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DW; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k <= DW; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[DW];
        end
    end

endmodule
`default_nettype wire

@@ sv/diag_measuring_value_scaler_core.sv @@
// Top level of the measuring value scaler: decode, queue, divider back end.
// Depends on dmvs_pkg, dmvs_front, dmvs_fifo, dmvs_back.
//
// Usage:
//   Input queue side: drive i_item and raise push; a transfer happens at a
//   rising edge with push high and full low. Output queue side: while empty
//   is low, o_result holds the oldest result; a transfer happens at a rising
//   edge with pop high and empty low. Each triple gives exactly one result.
//   Throughput: one triple per cycle, sustained while pop is held high.
//   After the input transfer, a triple passes the queue, the divider input
//   register, the restoring divider stages, which retire one quotient bit
//   per stage, and the result register before empty goes low.
//   If a result waits and pop is low, the pipeline freezes; the four-entry
//   input queue keeps taking triples until it fills, then full goes high.
//   Reset (synchronous, i_rst_n low) empties the queue and the pipeline;
//   there is no configuration and no other state.
`default_nettype none
module diag_measuring_value_scaler_core #(
    parameter int FRACTION_BITS = 16
) (
    input  var logic           i_clk,
    input  var logic           i_rst_n,
    input  var dmvs_pkg::t_in  i_item,
    input  var logic           push,
    output var logic           full,
    output var dmvs_pkg::t_out o_result,
    output var logic           empty,
    input  var logic           pop
);
    import dmvs_pkg::*;

    t_item dec_item, q_item;
    logic  q_empty, take;

    dmvs_front u_front (
        .i_item (i_item),
        .o_item (dec_item)
    );

    dmvs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (dec_item),
        .i_rd    (take),
        .o_data  (q_item),
        .o_full  (full),
        .o_empty (q_empty)
    );

    dmvs_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (q_item),
        .i_vld    (!q_empty),
        .o_take   (take),
        .o_result (o_result),
        .o_empty  (empty),
        .i_pop    (pop)
    );

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.type_known) |-> (o_result.scaled_value == '0))
        else $error("unknown type gave nonzero value");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("pending result lost while stalled");

endmodule
`default_nettype wire

@@ dv/diag_measuring_value_scaler_core_test.sv @@
// Testbench for diag_measuring_value_scaler_core: directed and random measuring triples,
// checked against an in-bench fixed-point predictor. Depends on dmvs_pkg and the core.
`timescale 1ns / 100ps
module diag_measuring_value_scaler_core_test;
    import dmvs_pkg::*;

    localparam int FB = 16;
    localparam int WATCH_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    t_in  i_item;
    logic push;
    logic full;
    t_out o_result;
    logic empty;
    logic pop;

    t_out scaled_q[$];
    int   fails;
    int   idle_cycles;
    bit   quiet;
    bit   hold_rx;

    diag_measuring_value_scaler_core #(.FRACTION_BITS(FB)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .push(push), .full(full),
        .o_result(o_result), .empty(empty), .pop(pop)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint fx_round(longint num, longint den);
        longint mag;
        longint q;
        bit neg;
        neg = num < 0;
        mag = (neg ? -num : num) * (64'sd1 <<< FB);
        if (den == 0) den = 1;
        q = (2 * mag + den) / (2 * den);
        if (neg) begin
            if (q > 64'sd34359738368) q = 64'sd34359738368;
            return -q;
        end
        if (q > 64'sd34359738367) q = 64'sd34359738367;
        return q;
    endfunction

    function automatic t_out scale(t_in it);
        longint a, b, ab, w, num, den;
        bit known;
        t_out r;
        a = it.value_a; b = it.value_b; ab = a * b; w = 256 * a + b;
        num = 0; den = 1; known = 1'b1;
        case (it.formula_type)
            FT_01: begin num = ab; den = 5; end
            FT_02, FT_03: begin num = ab; den = 500; end
            FT_04: begin num = (b >= 127 ? b - 127 : 127 - b) * a; den = 100; end
            FT_05: begin num = a * (b - 100); den = 10; end
            FT_06, FT_12, FT_21, FT_22, FT_24, FT_45: begin num = ab; den = 1000; end
            FT_07, FT_15, FT_19, FT_35: begin num = ab; den = 100; end
            FT_08: begin num = ab; den = 10; end
            FT_09: begin num = (b - 127) * a; den = 50; end
            FT_11: begin num = a * (b - 128) + 10000; den = 10000; end
            FT_13: begin num = (b - 127) * a; den = 1000; end
            FT_14, FT_55: begin num = ab; den = 200; end
            FT_18: begin num = ab; den = 25; end
            FT_20: begin num = a * (b - 128); den = 128; end
            FT_23, FT_39: begin num = ab; den = 256; end
            FT_25: begin num = 1000 * a + 182 * 1421 * b; den = 182000; end
            FT_26, FT_28: num = b - a;
            FT_27: begin num = (b >= 128 ? b - 128 : 128 - b) * a; den = 100; end
            FT_30: begin num = ab; den = 12; end
            FT_31: begin num = ab; den = 2560; end
            FT_33: num = (a == 0) ? 100 * b : (100 * b) / a;
            FT_34: begin num = (b - 128) * a; den = 100; end
            FT_38: begin num = (b - 128) * a; den = 1000; end
            FT_43: begin num = b + 255 * a; den = 10; end
            FT_46: begin num = (ab - 3200) * 27; den = 10000; end
            FT_47: num = (b - 128) * a;
            FT_49: begin num = ab; den = 40; end
            FT_50: begin num = (b - 128) * 100; if (a != 0) den = a; end
            FT_51: begin num = (b - 128) * a; den = 255; end
            FT_52: begin num = ab - 50 * a; den = 50; end
            FT_53: begin num = (b - 128) * 14222 + 60 * a; den = 10000; end
            FT_48, FT_54, FT_56: num = w;
            FT_59: begin num = w; den = 32768; end
            FT_60: begin num = w; den = 100; end
            FT_61: begin num = b - 128; if (a != 0) den = a; end
            FT_62: begin num = 256 * ab; den = 1000; end
            FT_64: num = a + b;
            FT_65: begin num = a * (b - 127); den = 100; end
            FT_66: begin num = ab * 100; den = 51112; end
            FT_67: begin num = 1280 * a + 5 * b; den = 2; end
            FT_68: begin num = w * 1000; den = 7365; end
            FT_69: begin num = w * 3254; den = 10000; end
            FT_70: begin num = w * 192; den = 1000; end
            default: known = 1'b0;
        endcase
        r.scaled_value = known ? OUTW'(fx_round(num, den)) : '0;
        r.type_known = known;
        return r;
    endfunction

    task automatic send(input logic [7:0] t, input logic [7:0] a, input logic [7:0] b);
        t_in it;
        int gap;
        it.formula_type = t; it.value_a = a; it.value_b = b;
        if (!quiet && $urandom_range(3) == 0) begin
            gap = $urandom_range(11, 1);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item <= it;
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        scaled_q.push_back(scale(it));
    endtask

    // transfer checking and receiver stalls
    initial begin
        int stall;
        stall = 0;
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (scaled_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_result);
                    fails++;
                end else begin
                    t_out e;
                    e = scaled_q.pop_front();
                    if (e.scaled_value !== o_result.scaled_value)
                        begin
                        $display("%0t: scaled_value expected %h actual %h",
                                 $time, e.scaled_value, o_result.scaled_value);
                        fails++;
                    end
                    if (e.type_known !== o_result.type_known) begin
                        $display("%0t: type_known expected %b actual %b",
                                 $time, e.type_known, o_result.type_known);
                        fails++;
                    end
                end
            end
            if (hold_rx) pop <= 1'b0;
            else if (stall > 0) begin
                stall--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(4) == 0) begin
                stall = $urandom_range(11, 1) - 1;
                pop <= 1'b0;
            end else pop <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer, cleared while hold_rx is set
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || hold_rx) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic test_corners;
        logic [7:0] ext[4];
        ext = '{8'd0, 8'd1, 8'd128, 8'd255};
        send(FT_33, 8'd0, 8'd255);
        send(FT_33, 8'd7, 8'd200);
        send(FT_50, 8'd0, 8'd0);
        send(FT_50, 8'd3, 8'd255);
        send(FT_61, 8'd0, 8'd255);
        send(FT_61, 8'd255, 8'd0);
        send(FT_59, 8'd255, 8'd255);
        send(8'd0, 8'd12, 8'd34);
        send(8'd255, 8'd255, 8'd255);
        send(8'd10, 8'd5, 8'd5);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                if (i == j || i + j == 3) send(FT_46, ext[i], ext[j]);
    endtask

    task automatic test_all_types;
        for (int t = 0; t < 256; t++)
            send(t[7:0], 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic test_backpressure;
        hold_rx = 1'b1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            for (int k = 0; k < 100; k++)
                send(8'($urandom_range(71)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        join
    endtask

    task automatic test_random(input int n);
        logic [7:0] t;
        for (int k = 0; k < n; k++) begin
            t = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(70));
            case ($urandom_range(5))
                0: send(t, 8'd0, 8'($urandom_range(255)));
                1: send(t, 8'($urandom_range(255)), ($urandom_range(1) != 0) ? 8'd255 : 8'd127);
                default: send(t, 8'($urandom_range(255)), 8'($urandom_range(255)));
            endcase
        end
    endtask

    initial begin
        int waited;
        fails = 0; quiet = 1'b0; hold_rx = 1'b0;
        i_rst_n = 1'b0; push = 1'b0; i_item = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_all_types();
        test_backpressure();
        test_random(1040);
        quiet = 1'b1;
        test_random(200);
        push <= 1'b0;
        waited = 0;
        while (scaled_q.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (fails == 0 && scaled_q.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
